// ===== rtl/tsw_pkg.sv =====
// Shared types and constants for the timeline semaphore waiter table.
// Used by tsw_cmp and timeline_semaphore_waiter_table; no dependencies.
`default_nettype none
package tsw_pkg;

	localparam int WAITERS = 16;
	localparam int CNT_W   = $clog2(WAITERS + 1);
	localparam int IDX_W   = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int VAL_W   = 64;
	localparam int ID_W    = 8;
	localparam int ENTRY_W = VAL_W + ID_W;

	typedef enum logic [1:0] {
		CMD_SIGNAL = 2'd0,
		CMD_INC    = 2'd1,
		CMD_REG    = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_NOT_ADV     = 3'd1,
		STS_EXCEEDS     = 3'd2,
		STS_FULL        = 3'd3,
		STS_NOT_REACHED = 3'd4
	} status_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	localparam logic CFG_INITIAL = 1'b0;
	localparam logic CFG_MAX     = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] target;
		logic [ID_W-1:0]  handle;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} tbl_wr_t;

	typedef struct packed {
		logic             kind;
		status_t          status;
		logic [VAL_W-1:0] value;
		logic [ID_W-1:0]  id;
		logic             last;
	} item_t;

endpackage
`default_nettype wire

// ===== rtl/tsw_cmp.sv =====
// Shared 64-bit unsigned magnitude compare (a >= b).
// Depends on tsw_pkg.
`default_nettype none
module tsw_cmp (
	input  wire logic [tsw_pkg::VAL_W-1:0] a,
	input  wire logic [tsw_pkg::VAL_W-1:0] b,
	output logic                           ge
);

	assign ge = (a >= b);

endmodule
`default_nettype wire

// ===== rtl/tsw_table.sv =====
// Generic single-port-write RAM with a registered read port.
// No dependencies; width and depth come from the instantiating module.
`default_nettype none
module tsw_table #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

// ===== rtl/timeline_semaphore_waiter_table.sv =====
// Timeline semaphore with a bounded, insertion-ordered waiter table.
// Depends on tsw_pkg, tsw_cmp, tsw_table.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: command; tdata: value, waiter_id
//  m_*      out  m_tvalid/m_tready  tuser: kind; tdata: status, value_res, waiter_id_res;
//                                   tlast: last
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Advancing signal/increment: accept, advance check, max check, one step per stored
// waiter through the shared comparator, final status. A rejected one ends after the
// advance check (not advancing) or the max check (above max). Others: accept, one check.
// Table reads are registered; the next slot address is issued while the current slot is examined.
// Input is taken only while the sequencer is idle; a held result in the output
// register stalls the sequencer until taken. Reset: timeline 0, table empty.
`default_nettype none
module timeline_semaphore_waiter_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // [63:0] value, [71:64] waiter_id
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [2:0] status, [66:3] value_res,
	                                    // [74:67] waiter_id_res, [79:75] zero
	output logic [0:0]       m_tuser,   // [0] kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHK1,
		S_CHK2,
		S_SCAN
	} state_t;

	state_t                          state_q;
	tsw_pkg::cmd_t                   cmd_q;
	logic [tsw_pkg::VAL_W-1:0]       nv_q;
	logic [tsw_pkg::ID_W-1:0]        id_q;
	logic [tsw_pkg::VAL_W-1:0]       cur_q;
	logic [tsw_pkg::VAL_W-1:0]       max_q;
	logic [tsw_pkg::CNT_W-1:0]       cnt_q;
	logic [tsw_pkg::CNT_W-1:0]       scn_q;
	logic [tsw_pkg::CNT_W-1:0]       keep_q;
	logic                            out_vld_q;
	tsw_pkg::item_t                  out_q;

	logic [tsw_pkg::VAL_W-1:0]       cmp_a;
	logic [tsw_pkg::VAL_W-1:0]       cmp_b;
	logic                            ge;
	logic                            out_free;
	logic                            full;
	logic                            scan_done;
	logic                            out_load;
	tsw_pkg::item_t                  out_item;
	tsw_pkg::tbl_wr_t                tbl_wr;
	logic [tsw_pkg::IDX_W-1:0]       rd_addr;
	logic [tsw_pkg::ENTRY_W-1:0]     rd_data;
	tsw_pkg::entry_t                 rd_entry;

	function automatic tsw_pkg::item_t mk_item(logic k, tsw_pkg::status_t s,
			logic [tsw_pkg::VAL_W-1:0] v, logic [tsw_pkg::ID_W-1:0] i, logic l);
		tsw_pkg::item_t it;
		it.kind   = k;
		it.status = s;
		it.value  = v;
		it.id     = i;
		it.last   = l;
		return it;
	endfunction

	assign out_free  = !out_vld_q || m_tready;
	assign full      = (cnt_q >= tsw_pkg::CNT_W'(tsw_pkg::WAITERS));
	assign scan_done = (scn_q == cnt_q);
	assign s_tready  = (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_CHK2: begin
				cmp_a = max_q;
				cmp_b = nv_q;
			end
			S_SCAN: begin
				cmp_a = nv_q;
				cmp_b = rd_entry.target;
			end
			default: begin
				cmp_a = cur_q;
				cmp_b = nv_q;
			end
		endcase
	end

	tsw_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.ge (ge)
	);

	always_comb begin
		tbl_wr.we           = 1'b0;
		tbl_wr.addr         = cnt_q[tsw_pkg::IDX_W-1:0];
		tbl_wr.entry.target = nv_q;
		tbl_wr.entry.handle = id_q;
		if (state_q == S_CHK1) begin
			tbl_wr.we = out_free && (cmd_q == tsw_pkg::CMD_REG) && !ge && !full;
		end else if (state_q == S_SCAN) begin
			tbl_wr.we    = out_free && !scan_done && !ge;
			tbl_wr.addr  = keep_q[tsw_pkg::IDX_W-1:0];
			tbl_wr.entry = rd_entry;
		end
	end

	// address of the slot examined in the next cycle
	always_comb begin
		case (state_q)
			S_SCAN: begin
				rd_addr = (out_free && !scan_done) ?
					scn_q[tsw_pkg::IDX_W-1:0] + tsw_pkg::IDX_W'(1) :
					scn_q[tsw_pkg::IDX_W-1:0];
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	tsw_table #(
		.WIDTH (tsw_pkg::ENTRY_W),
		.DEPTH (tsw_pkg::WAITERS)
	) u_table (
		.clk   (clk),
		.we    (tbl_wr.we),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.entry),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign rd_entry = tsw_pkg::entry_t'(rd_data);

	always_comb begin
		out_load = 1'b0;
		out_item = mk_item(tsw_pkg::KIND_STATUS, tsw_pkg::STS_OK, cur_q, '0, 1'b1);
		if (out_free) begin
			case (state_q)
				S_CHK1: begin
					case (cmd_q)
						tsw_pkg::CMD_SIGNAL, tsw_pkg::CMD_INC: begin
							out_load = ge;
							out_item = mk_item(tsw_pkg::KIND_STATUS,
								tsw_pkg::STS_NOT_ADV, cur_q, '0, 1'b1);
						end
						tsw_pkg::CMD_REG: begin
							out_load = 1'b1;
							if (ge) begin
								out_item = mk_item(tsw_pkg::KIND_FIRED,
									tsw_pkg::STS_OK, cur_q, id_q, 1'b1);
							end else if (full) begin
								out_item = mk_item(tsw_pkg::KIND_STATUS,
									tsw_pkg::STS_FULL, cur_q, '0, 1'b1);
							end
						end
						default: begin
							out_load = 1'b1;
							out_item = mk_item(tsw_pkg::KIND_STATUS,
								ge ? tsw_pkg::STS_OK : tsw_pkg::STS_NOT_REACHED,
								cur_q, '0, 1'b1);
						end
					endcase
				end
				S_CHK2: begin
					out_load = !ge;
					out_item = mk_item(tsw_pkg::KIND_STATUS,
						tsw_pkg::STS_EXCEEDS, cur_q, '0, 1'b1);
				end
				S_SCAN: begin
					out_load = scan_done || ge;
					if (!scan_done) begin
						out_item = mk_item(tsw_pkg::KIND_FIRED,
							tsw_pkg::STS_OK, nv_q, rd_entry.handle, 1'b0);
					end
				end
				default: begin
					out_load = 1'b0;
				end
			endcase
		end
	end

	// the start value register resets to zero along with the timeline, so its writes
	// never become visible and it is not kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= tsw_pkg::CMD_SIGNAL;
			nv_q      <= '0;
			id_q      <= '0;
			cur_q     <= '0;
			max_q     <= '1;
			cnt_q     <= '0;
			scn_q     <= '0;
			keep_q    <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (cfg_we && (cfg_index == tsw_pkg::CFG_MAX)) begin
				max_q <= cfg_data;
			end
			if (out_load) begin
				out_q     <= out_item;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= tsw_pkg::cmd_t'(s_tuser);
						nv_q    <= (tsw_pkg::cmd_t'(s_tuser) == tsw_pkg::CMD_INC) ?
							cur_q + 64'd1 : s_tdata[63:0];
						id_q    <= s_tdata[71:64];
						state_q <= S_CHK1;
					end
				end
				S_CHK1: begin
					if (out_free) begin
						if (((cmd_q == tsw_pkg::CMD_SIGNAL) ||
								(cmd_q == tsw_pkg::CMD_INC)) && !ge) begin
							state_q <= S_CHK2;
						end else begin
							state_q <= S_IDLE;
						end
						if ((cmd_q == tsw_pkg::CMD_REG) && !ge && !full) begin
							cnt_q <= cnt_q + tsw_pkg::CNT_W'(1);
						end
					end
				end
				S_CHK2: begin
					if (ge) begin
						cur_q   <= nv_q;
						scn_q   <= '0;
						keep_q  <= '0;
						state_q <= S_SCAN;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (out_free) begin
						if (scan_done) begin
							cnt_q   <= keep_q;
							state_q <= S_IDLE;
						end else begin
							if (!ge) begin
								keep_q <= keep_q + tsw_pkg::CNT_W'(1);
							end
							scn_q <= scn_q + tsw_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, out_q.id, out_q.value, out_q.status};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tsw_pkg::CNT_W'(tsw_pkg::WAITERS))
		else $error("waiter count beyond table size");

	a_keep_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (keep_q <= scn_q))
		else $error("compaction index ahead of scan index");

	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cur_q >= $past(cur_q)))
		else $error("timeline value went backward");

endmodule
`default_nettype wire
